// File: rtl/krt_pkg.sv
package krt_pkg;

    // Number of record slots, one cell each.
    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int USED_W      = 5;

    typedef enum logic [FUNC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // One stored record as it sits in a cell.
    typedef struct packed {
        logic              vld;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] qty;
        logic [DATA_W-1:0] val;
    } rec_t;

    // A request walking down the chain. For an insert, vld/key/qty/val carry
    // the record that is pushed back one cell; for a lookup, qty/val pick up
    // the matching record.
    typedef struct packed {
        logic              live;
        op_t               op;
        logic              full;
        logic              found;
        logic              vld;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] qty;
        logic [DATA_W-1:0] val;
    } tok_t;

endpackage

// File: rtl/krt_cell.sv
module krt_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  krt_pkg::tok_t tok_in,
    input  krt_pkg::rec_t nbr_rec,
    output krt_pkg::tok_t tok_out,
    output krt_pkg::rec_t rec_out
);

    krt_pkg::rec_t rec_reg;
    krt_pkg::rec_t rec_next;
    krt_pkg::tok_t tok_reg;
    krt_pkg::tok_t tok_next;
    logic          hit;

    // This cell holds the newest match if no earlier cell claimed the request.
    assign hit = tok_in.live && rec_reg.vld && (rec_reg.key == tok_in.key) &&
                 !tok_in.found &&
                 ((tok_in.op == krt_pkg::OP_LOOKUP) || (tok_in.op == krt_pkg::OP_REMOVE));

    always_comb begin
        rec_next       = rec_reg;
        tok_next       = tok_in;
        tok_next.found = tok_in.found || hit;
        if (tok_in.live && !tok_in.full) begin
            case (tok_in.op)
                krt_pkg::OP_INSERT: begin
                    rec_next     = '{vld: tok_in.vld, key: tok_in.key,
                                     qty: tok_in.qty, val: tok_in.val};
                    tok_next.vld = rec_reg.vld;
                    tok_next.key = rec_reg.key;
                    tok_next.qty = rec_reg.qty;
                    tok_next.val = rec_reg.val;
                end
                krt_pkg::OP_LOOKUP: begin
                    if (hit) begin
                        tok_next.qty = rec_reg.qty;
                        tok_next.val = rec_reg.val;
                    end
                end
                krt_pkg::OP_REMOVE: begin
                    // The matching cell and every cell behind it pull the
                    // record from the right, which has not moved yet.
                    if (tok_in.found || hit) begin
                        rec_next = nbr_rec;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg.vld <= 1'b0;
            tok_reg.live <= 1'b0;
        end else begin
            rec_reg.vld <= rec_next.vld;
            tok_reg.live <= tok_next.live;
        end
        rec_reg.key   <= rec_next.key;
        rec_reg.qty   <= rec_next.qty;
        rec_reg.val   <= rec_next.val;
        tok_reg.op    <= tok_next.op;
        tok_reg.full  <= tok_next.full;
        tok_reg.found <= tok_next.found;
        tok_reg.vld   <= tok_next.vld;
        tok_reg.key   <= tok_next.key;
        tok_reg.qty   <= tok_next.qty;
        tok_reg.val   <= tok_next.val;
    end

    assign tok_out = tok_reg;
    assign rec_out = rec_reg;

endmodule

// File: rtl/keyed_record_table_unit.sv
// Keyed record table: up to TABLE_DEPTH records of key, quantity and value,
// kept newest first in a row of cells, one record per cell.
// The request channel (s_*) carries func, key_code, in_quantity and in_value;
// func selects insert, lookup by key or remove by key, and code 3 does nothing.
// The result channel (m_*) returns one result per request: status, the found
// quantity and value (zero unless a lookup hits) and the record count after
// the request.
// A request walks the cell row one cell per cycle, passing the head register,
// the cells and the done register before it reaches the output register. The
// table works on one request at a time and takes the next only once the
// previous result has left the done register for the output register.
// A finished result sits in the output register, and the next request is
// accepted at once behind it. If the receiver stalls, the following result
// waits in a holding register and s_ready stays low until it can move on.
// Reset (aresetn low, synchronous) empties the table and drops any request
// in flight; record contents are not cleared, only their valid bits.
module keyed_record_table_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [krt_pkg::FUNC_W-1:0]          s_func,
    input  logic signed [krt_pkg::DATA_W-1:0]   s_key_code,
    input  logic signed [krt_pkg::DATA_W-1:0]   s_in_quantity,
    input  logic [krt_pkg::DATA_W-1:0]          s_in_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [krt_pkg::STATUS_W-1:0]        m_status,
    output logic signed [krt_pkg::DATA_W-1:0]   m_out_quantity,
    output logic [krt_pkg::DATA_W-1:0]          m_out_value,
    output logic [krt_pkg::USED_W-1:0]          m_entries_used
);

    localparam int DEPTH = krt_pkg::TABLE_DEPTH;
    localparam int CW    = krt_pkg::CNT_W;

    // Token and record links between neighboring cells. Position DEPTH of
    // the record links is the empty slot beyond the last cell.
    krt_pkg::tok_t tok_link [0:DEPTH];
    krt_pkg::rec_t rec_link [0:DEPTH];

    krt_pkg::tok_t            head_reg;
    krt_pkg::tok_t            head_next;
    krt_pkg::tok_t            done_reg;
    logic                     busy_reg;
    logic [CW-1:0]            count_reg;
    logic                     out_valid_reg;
    krt_pkg::status_t         out_status_reg;
    logic [krt_pkg::DATA_W-1:0] out_qty_reg;
    logic [krt_pkg::DATA_W-1:0] out_val_reg;
    logic [krt_pkg::USED_W-1:0] out_used_reg;

    logic                     in_fire;
    logic                     out_free;
    logic                     deliver;
    logic                     table_full;
    krt_pkg::tok_t            tail;
    krt_pkg::status_t         res_status;

    assign in_fire    = s_valid && s_ready;
    assign out_free   = !out_valid_reg || m_ready;
    assign deliver    = done_reg.live && out_free;
    assign table_full = (count_reg == CW'(DEPTH));
    assign s_ready    = !busy_reg;
    assign tail       = tok_link[DEPTH];

    // Build the request token. An insert into a full table still walks the
    // row, but marked full so that no cell touches its record.
    always_comb begin
        head_next       = head_reg;
        head_next.live  = in_fire;
        if (in_fire) begin
            head_next.op    = krt_pkg::op_t'(s_func);
            head_next.full  = (krt_pkg::op_t'(s_func) == krt_pkg::OP_INSERT) && table_full;
            head_next.found = 1'b0;
            head_next.vld   = 1'b1;
            head_next.key   = s_key_code;
            head_next.qty   = s_in_quantity;
            head_next.val   = s_in_value;
        end
    end

    assign tok_link[0]     = head_reg;
    assign rec_link[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        krt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok_link[i]),
            .nbr_rec (rec_link[i+1]),
            .tok_out (tok_link[i+1]),
            .rec_out (rec_link[i])
        );
    end

    // Result of the request that left the last cell.
    always_comb begin
        res_status = krt_pkg::ST_OK;
        if (done_reg.full) begin
            res_status = krt_pkg::ST_FULL;
        end else if (((done_reg.op == krt_pkg::OP_LOOKUP) ||
                      (done_reg.op == krt_pkg::OP_REMOVE)) && !done_reg.found) begin
            res_status = krt_pkg::ST_MISS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg.live <= 1'b0;
            done_reg.live <= 1'b0;
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg.live <= head_next.live;
            if (in_fire) begin
                busy_reg <= 1'b1;
            end else if (deliver) begin
                busy_reg <= 1'b0;
            end
            // The count changes once, when the request leaves the row.
            if (tail.live) begin
                done_reg.live <= 1'b1;
                if (tail.op == krt_pkg::OP_INSERT && !tail.full) begin
                    count_reg <= count_reg + CW'(1);
                end else if (tail.op == krt_pkg::OP_REMOVE && tail.found) begin
                    count_reg <= count_reg - CW'(1);
                end
            end else if (deliver) begin
                done_reg.live <= 1'b0;
            end
            if (deliver) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        head_reg.op    <= head_next.op;
        head_reg.full  <= head_next.full;
        head_reg.found <= head_next.found;
        head_reg.vld   <= head_next.vld;
        head_reg.key   <= head_next.key;
        head_reg.qty   <= head_next.qty;
        head_reg.val   <= head_next.val;
        if (tail.live) begin
            done_reg.op    <= tail.op;
            done_reg.full  <= tail.full;
            done_reg.found <= tail.found;
            done_reg.vld   <= tail.vld;
            done_reg.key   <= tail.key;
            done_reg.qty   <= tail.qty;
            done_reg.val   <= tail.val;
        end
        if (deliver) begin
            out_status_reg <= res_status;
            out_used_reg   <= krt_pkg::USED_W'(count_reg);
            if (done_reg.op == krt_pkg::OP_LOOKUP && done_reg.found) begin
                out_qty_reg <= done_reg.qty;
                out_val_reg <= done_reg.val;
            end else begin
                out_qty_reg <= '0;
                out_val_reg <= '0;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_status_reg;
    assign m_out_quantity = out_qty_reg;
    assign m_out_value    = out_val_reg;
    assign m_entries_used = out_used_reg;

    // A finished request is only held while the table counts itself busy.
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg.live |-> busy_reg)
        else $error("finished request held while table idle");

    // The record count never passes the number of cells.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("record count beyond table depth");

    // A new request is never accepted while one is still walking the row.
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !tail.live && !done_reg.live)
        else $error("request accepted while another in flight");

endmodule
